@@ hdl/lfpd_pkg.sv @@
// Shared constants, register codes and the servo mapping for the line-follow PID drive.
// No dependencies; every other file imports it.
package lfpd_pkg;

	localparam int SENSOR_W   = 8;
	localparam int SPEED_W    = 8;
	localparam int CODE_W     = 8;
	localparam int GAIN_W     = 16;
	localparam int BASE_W     = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int FRAC_BITS  = 12;

	localparam int DEF_HISTORY_DEPTH = 5;
	localparam int DEF_SENSOR_BITS   = 8;

	localparam int SPEED_LIMIT   = 100;
	localparam int SERVO_CENTER  = 127;
	localparam int RECIP_10      = 205;
	localparam int RECIP_10_SHIFT = 11;

	localparam logic signed [BASE_W-1:0] BASE_SPEED_RST = 8'sd45;
	localparam logic [GAIN_W-1:0]        GAIN_P_RST     = 16'd819;
	localparam logic [GAIN_W-1:0]        GAIN_I_RST     = 16'd205;
	localparam logic [GAIN_W-1:0]        GAIN_D_RST     = 16'd410;

	localparam logic signed [SPEED_W-1:0] SPEED_MAX = SPEED_W'(SPEED_LIMIT);
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = -SPEED_W'(SPEED_LIMIT);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_SPEED = 2'd0,
		REG_GAIN_P     = 2'd1,
		REG_GAIN_I     = 2'd2,
		REG_GAIN_D     = 2'd3
	} cfg_reg_t;

	// (s*3)/10 + 127, truncated toward zero
	function automatic logic [CODE_W-1:0] servo_code(input logic signed [SPEED_W-1:0] s);
		logic [SPEED_W-1:0] mag;
		logic [15:0]        prod;
		logic [CODE_W-1:0]  q;
		mag  = s[SPEED_W-1] ? SPEED_W'(-s) : SPEED_W'(s);
		prod = 16'(mag) * 16'(3 * RECIP_10);
		q    = CODE_W'(prod >> RECIP_10_SHIFT);
		return s[SPEED_W-1] ? CODE_W'(SERVO_CENTER) - q : CODE_W'(SERVO_CENTER) + q;
	endfunction

endpackage

@@ hdl/lfpd_ifs.sv @@
// Valid/ready channel interfaces: sensor sample pairs in, drive speeds and servo codes out.
// Depends on lfpd_pkg.
interface lfpd_sensor_if import lfpd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SENSOR_W-1:0] left_reading;
	logic [SENSOR_W-1:0] right_reading;

	modport source(output valid, left_reading, right_reading, input ready);
	modport sink(input valid, left_reading, right_reading, output ready);
endinterface

interface lfpd_drive_if import lfpd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] left_speed;
	logic signed [SPEED_W-1:0] right_speed;
	logic [CODE_W-1:0]         left_servo_code;
	logic [CODE_W-1:0]         right_servo_code;

	modport source(output valid, left_speed, right_speed, left_servo_code, right_servo_code,
		input ready);
	modport sink(input valid, left_speed, right_speed, left_servo_code, right_servo_code,
		output ready);
endinterface

@@ hdl/line_follow_pid_drive_top.sv @@
// Top level of the line-follow PID drive: error history, PID terms, saturation, servo codes.
// Depends on lfpd_pkg and the channel interfaces in lfpd_ifs.sv.
//
// One sensor beat is taken per clock while stage one can advance, and it leaves as a drive
// beat at the end of the eight-stage pipeline (history update, gain multiplies, reciprocal
// multiply for the history average, its correction, term sum, side sums, saturation, servo
// mapping). Each stage stalls only when the stage after it is full and stalled, so bubbles
// are squeezed out and beats move on into empty stages while a finished result waits at
// the output. The history sum is kept as a running total, updated as each beat enters.
// Configuration writes take effect at once and belong in idle periods only.
module line_follow_pid_drive_top import lfpd_pkg::*; #(
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
	parameter int SENSOR_BITS   = DEF_SENSOR_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	lfpd_sensor_if.sink           sensor,
	lfpd_drive_if.source          drive
);

	localparam int EB     = (SENSOR_BITS < SENSOR_W) ? SENSOR_BITS : SENSOR_W;
	localparam int ERR_W  = EB + 1;
	localparam int SUM_W  = ERR_W + $clog2(HISTORY_DEPTH);
	localparam int A_W    = GAIN_W + SUM_W - 1;
	localparam int P_W    = GAIN_W + 1 + ERR_W;
	localparam int I_W    = GAIN_W + 2 + ERR_W;
	localparam int MX1    = (A_W + 1 > I_W) ? A_W + 1 : I_W;
	localparam int MX2    = (MX1 > BASE_W + FRAC_BITS) ? MX1 : BASE_W + FRAC_BITS;
	localparam int Q_W    = MX2 + 3;
	localparam int NSTAGE = 8;

	localparam logic [A_W:0]   RECIP   = (A_W + 1)'((64'd1 << A_W) / HISTORY_DEPTH);
	localparam logic [A_W-1:0] DEPTH_K = A_W'(HISTORY_DEPTH);
	localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((SPEED_LIMIT + 1) * (1 << FRAC_BITS));
	localparam logic signed [Q_W-1:0] SAT_LO = -SAT_HI;

	function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [Q_W-1:0] q);
		logic signed [Q_W-1:0]     fl;
		logic signed [SPEED_W-1:0] s;
		fl = q >>> FRAC_BITS;
		s  = SPEED_W'(fl);
		if (q[Q_W-1] && (q[FRAC_BITS-1:0] != '0))
			s = s + SPEED_W'(1);
		if (q >= SAT_HI)
			s = SPEED_MAX;
		else if (q <= SAT_LO)
			s = SPEED_MIN;
		return s;
	endfunction

	logic signed [BASE_W-1:0] base_speed_q;
	logic [GAIN_W-1:0]        gain_p_q, gain_i_q, gain_d_q;

	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] en;

	logic signed [ERR_W-1:0] hist_q [HISTORY_DEPTH];
	logic signed [SUM_W-1:0] sum_q;

	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W:0]   esum;
	logic signed [SUM_W-1:0] sum_nxt;
	logic accept;

	logic signed [ERR_W-1:0] err_s1;
	logic signed [ERR_W:0]   esum_s1;
	logic signed [SUM_W-1:0] sum_s1;

	logic [SUM_W-2:0]     sabs;
	logic signed [P_W-1:0] p_s2, p_s3, p_s4;
	logic signed [I_W-1:0] i_s2, i_s3, i_s4;
	logic [A_W-1:0]        dabs_s2, dabs_s3;
	logic                  dneg_s2, dneg_s3;

	logic [2*A_W:0]        prod;
	logic [A_W-1:0]        q0_s3;
	logic [A_W-1:0]        rem;
	logic [A_W-1:0]        qf;
	logic signed [Q_W-1:0] dterm_s4;
	logic signed [Q_W-1:0] t_s5;
	logic signed [Q_W-1:0] bterm;
	logic signed [Q_W-1:0] lq_s6, rq_s6;
	logic signed [SPEED_W-1:0] ls_s7, rs_s7;
	logic signed [SPEED_W-1:0] ls_s8, rs_s8;
	logic [CODE_W-1:0]         lcode_s8, rcode_s8;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q <= BASE_SPEED_RST;
			gain_p_q     <= GAIN_P_RST;
			gain_i_q     <= GAIN_I_RST;
			gain_d_q     <= GAIN_D_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_SPEED: base_speed_q <= cfg_wr_data[BASE_W-1:0];
				REG_GAIN_P:     gain_p_q     <= cfg_wr_data[GAIN_W-1:0];
				REG_GAIN_I:     gain_i_q     <= cfg_wr_data[GAIN_W-1:0];
				REG_GAIN_D:     gain_d_q     <= cfg_wr_data[GAIN_W-1:0];
			endcase
		end
	end

	// stage enables: advance when empty or when the next stage advances
	always_comb begin
		en[NSTAGE] = !vld_q[NSTAGE] || drive.ready;
		for (int k = NSTAGE - 1; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign sensor.ready = en[1];
	assign accept       = sensor.valid && en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= sensor.valid;
			for (int k = 2; k <= NSTAGE; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign err     = $signed({1'b0, sensor.left_reading[EB-1:0]})
		- $signed({1'b0, sensor.right_reading[EB-1:0]});
	assign esum    = (ERR_W + 1)'(err) + (ERR_W + 1)'(hist_q[0]);
	assign sum_nxt = sum_q + SUM_W'(err) - SUM_W'(hist_q[HISTORY_DEPTH-1]);

	// error history and its running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HISTORY_DEPTH; k++)
				hist_q[k] <= '0;
			sum_q <= '0;
		end else if (accept) begin
			for (int k = HISTORY_DEPTH - 1; k > 0; k--)
				hist_q[k] <= hist_q[k-1];
			hist_q[0] <= err;
			sum_q     <= sum_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			err_s1  <= err;
			esum_s1 <= esum;
			sum_s1  <= sum_nxt;
		end
	end

	assign sabs = sum_s1[SUM_W-1] ? (SUM_W-1)'(-sum_s1) : (SUM_W-1)'(sum_s1);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			p_s2    <= $signed({1'b0, gain_p_q}) * P_W'(err_s1);
			i_s2    <= $signed({1'b0, gain_i_q}) * I_W'(esum_s1);
			dabs_s2 <= A_W'(gain_d_q) * A_W'(sabs);
			dneg_s2 <= sum_s1[SUM_W-1];
		end
	end

	assign prod = (2*A_W + 1)'(dabs_s2) * (2*A_W + 1)'(RECIP);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			q0_s3   <= prod[2*A_W-1:A_W];
			dabs_s3 <= dabs_s2;
			dneg_s3 <= dneg_s2;
			p_s3    <= p_s2;
			i_s3    <= i_s2;
		end
	end

	assign rem = dabs_s3 - A_W'(q0_s3 * DEPTH_K);
	assign qf  = (rem >= DEPTH_K) ? q0_s3 + A_W'(1) : q0_s3;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			dterm_s4 <= dneg_s3 ? -Q_W'(qf) : Q_W'(qf);
			p_s4     <= p_s3;
			i_s4     <= i_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5])
			t_s5 <= Q_W'(p_s4) + Q_W'(i_s4) + dterm_s4;
	end

	assign bterm = Q_W'(base_speed_q) <<< FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			lq_s6 <= bterm + t_s5;
			rq_s6 <= bterm - t_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			ls_s7 <= sat_speed(lq_s6);
			rs_s7 <= sat_speed(rq_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			ls_s8    <= ls_s7;
			rs_s8    <= rs_s7;
			lcode_s8 <= servo_code(ls_s7);
			rcode_s8 <= servo_code(-rs_s7);
		end
	end

	assign drive.valid            = vld_q[NSTAGE];
	assign drive.left_speed       = ls_s8;
	assign drive.right_speed      = rs_s8;
	assign drive.left_servo_code  = lcode_s8;
	assign drive.right_servo_code = rcode_s8;

endmodule
